>>> rtl/rnh_pkg.sv
// ----------------------------------------------------------------------------
// rnh_pkg
// shared types and constants of the range normalized histogram core
// ----------------------------------------------------------------------------
package rnh_pkg;

    localparam int IDX_W     = 6;
    localparam int CNT_W     = 32;
    localparam int QUO_BITS  = 7;
    localparam int ADDR_MAXW = 12;

    localparam logic [IDX_W-1:0] DEFAULT_TOP = 6'd25;

    localparam logic [0:0] REG_BIN_TOP = 1'b0;

    typedef enum logic [1:0] {
        ACT_RANGE = 2'd0,
        ACT_COUNT = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RANGE,
        S_MUL,
        S_CMP,
        S_DIV,
        S_ROUND,
        S_READ,
        S_UPDATE
    } state_t;

endpackage

>>> rtl/rnh_ram.sv
// ----------------------------------------------------------------------------
// rnh_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module rnh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/range_normalized_histogram_core.sv
// ----------------------------------------------------------------------------
// range_normalized_histogram_core
// histogram engine with running min/max and range normalized binning
// ----------------------------------------------------------------------------
// a word is taken when start is high and busy is low; action selects range,
// count, read or clear. one result word per input word, shown for a single
// cycle with done high; the receiver cannot stall, so results are never held.
// range passes S_RANGE before done, read and clear S_READ and S_UPDATE; count
// passes S_MUL, S_CMP, then the 7-step restoring divider that forms the bin
// quotient and S_ROUND unless span is zero or the sample far out of range, and
// then S_READ and S_UPDATE, a read-modify-write with registered read data.
// one word is processed at a time; a new word may be taken in the done cycle.
// after reset the bin memory is swept to zero with busy high;
// register writes over the apb port are taken at any time.
// bin_top_index lives at address 0; zero there selects 25 bins above bin 0.
// ----------------------------------------------------------------------------
module range_normalized_histogram_core
    import rnh_pkg::*;
#(
    parameter int MAX_BINS    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    action,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [IDX_W-1:0]              bin_select,
    output logic                          done,
    output logic [IDX_W-1:0]              bin_index,
    output logic [CNT_W-1:0]              bin_count,
    output logic signed [SAMPLE_BITS-1:0] min_seen,
    output logic signed [SAMPLE_BITS-1:0] max_seen,
    output logic                          clamped
);

    localparam int SB = SAMPLE_BITS;
    localparam int AW = $clog2(MAX_BINS);
    localparam int PW = SB + IDX_W;
    localparam int DW = SB + QUO_BITS;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]       top_reg;
    logic [AW-1:0]          clr_reg, clr_next;
    logic signed [SB-1:0]   min_reg, min_next;
    logic signed [SB-1:0]   max_reg, max_next;
    logic                   valid_reg, valid_next;
    logic                   done_reg, done_next;

    action_t                act_reg, act_next;
    logic signed [SB-1:0]   smp_reg, smp_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   clamp_reg, clamp_next;
    logic                   neg_reg, neg_next;
    logic [SB-1:0]          span_reg, span_next;
    logic [PW-1:0]          prod_reg, prod_next;
    logic [DW-1:0]          rem_reg, rem_next;
    logic [DW-1:0]          dvs_reg, dvs_next;
    logic [QUO_BITS-1:0]    quo_reg, quo_next;
    logic [2:0]             step_reg, step_next;
    logic [IDX_W-1:0]       oidx_reg, oidx_next;
    logic [CNT_W-1:0]       ocnt_reg, ocnt_next;
    logic                   oclamp_reg, oclamp_next;

    logic [IDX_W-1:0]       etop;
    logic                   accept;
    logic signed [SB:0]     diff;
    logic signed [SB:0]     span_full;
    logic [SB-1:0]          mag;
    logic                   too_big;
    logic [SB:0]            two_rem;
    logic                   round_up;
    logic [QUO_BITS:0]      q_round;
    logic                   in_range;
    logic [CNT_W-1:0]       new_cnt;
    logic [ADDR_MAXW-1:0]   idx_wide;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [CNT_W-1:0]       ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [CNT_W-1:0]       ram_rdata;

    rnh_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_BINS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BIN_TOP) ? {26'd0, top_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= DEFAULT_TOP;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_BIN_TOP))
        begin
            top_reg <= pwdata[IDX_W-1:0];
        end
    end

    // effective top index
    always_comb
    begin
        etop = (top_reg == '0) ? DEFAULT_TOP : top_reg;
        if (int'(etop) > MAX_BINS - 1)
        begin
            etop = IDX_W'(MAX_BINS - 1);
        end
    end

    assign accept   = start && (state_reg == S_IDLE);
    assign busy     = (state_reg != S_IDLE);
    assign idx_wide = {{(ADDR_MAXW-IDX_W){1'b0}}, idx_reg};
    assign in_range = (int'(idx_reg) < MAX_BINS);

    // datapath terms
    assign diff      = {smp_reg[SB-1], smp_reg} - {min_reg[SB-1], min_reg};
    assign span_full = {max_reg[SB-1], max_reg} - {min_reg[SB-1], min_reg};
    assign mag       = diff[SB] ? SB'(-diff) : diff[SB-1:0];
    assign too_big   = {1'b0, prod_reg} >= {span_reg, {QUO_BITS{1'b0}}};
    assign two_rem   = {rem_reg[SB-1:0], 1'b0};
    assign round_up  = (two_rem > {1'b0, span_reg})
                       || ((two_rem == {1'b0, span_reg}) && quo_reg[0]);
    assign q_round   = {1'b0, quo_reg} + {{QUO_BITS{1'b0}}, round_up};

    always_comb
    begin
        unique case (act_reg)
            ACT_COUNT: new_cnt = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
            ACT_CLEAR: new_cnt = '0;
            default:   new_cnt = ram_rdata;
        endcase
        if (!in_range)
        begin
            new_cnt = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == AW'(MAX_BINS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (action_t'(action))
                        ACT_RANGE: state_next = S_RANGE;
                        ACT_COUNT: state_next = S_MUL;
                        default:   state_next = S_READ;
                    endcase
                end
            end
            S_RANGE:  state_next = S_IDLE;
            S_MUL:    state_next = S_CMP;
            S_CMP:
            begin
                if ((span_reg == '0) || too_big)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (step_reg == 3'(QUO_BITS - 1))
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:  state_next = S_READ;
            S_READ:   state_next = S_UPDATE;
            S_UPDATE: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        clr_next    = clr_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        valid_next  = valid_reg;
        done_next   = 1'b0;
        act_next    = act_reg;
        smp_next    = smp_reg;
        idx_next    = idx_reg;
        clamp_next  = clamp_reg;
        neg_next    = neg_reg;
        span_next   = span_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        oidx_next   = oidx_reg;
        ocnt_next   = ocnt_reg;
        oclamp_next = oclamp_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_wide[AW-1:0];
        ram_wdata   = new_cnt;
        ram_raddr   = idx_wide[AW-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next   = action_t'(action);
                    smp_next   = sample;
                    idx_next   = bin_select;
                    clamp_next = 1'b0;
                end
            end
            S_RANGE:
            begin
                if (!valid_reg)
                begin
                    min_next = smp_reg;
                    max_next = smp_reg;
                end
                else
                begin
                    if (smp_reg < min_reg)
                    begin
                        min_next = smp_reg;
                    end
                    if (smp_reg > max_reg)
                    begin
                        max_next = smp_reg;
                    end
                end
                valid_next  = 1'b1;
                done_next   = 1'b1;
                oidx_next   = '0;
                ocnt_next   = '0;
                oclamp_next = 1'b0;
            end
            S_MUL:
            begin
                neg_next  = diff[SB];
                span_next = span_full[SB-1:0];
                prod_next = PW'(mag) * PW'(etop);
            end
            S_CMP:
            begin
                rem_next  = DW'(prod_reg);
                dvs_next  = DW'({span_reg, {(QUO_BITS-1){1'b0}}});
                quo_next  = '0;
                step_next = '0;
                if (span_reg == '0)
                begin
                    idx_next   = '0;
                    clamp_next = 1'b0;
                end
                else if (too_big)
                begin
                    idx_next   = neg_reg ? '0 : etop;
                    clamp_next = 1'b1;
                end
            end
            S_DIV:
            begin
                if (rem_reg >= dvs_reg)
                begin
                    rem_next = rem_reg - dvs_reg;
                    quo_next = {quo_reg[QUO_BITS-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[QUO_BITS-2:0], 1'b0};
                end
                dvs_next  = dvs_reg >> 1;
                step_next = step_reg + 1'b1;
            end
            S_ROUND:
            begin
                if (neg_reg)
                begin
                    idx_next   = '0;
                    clamp_next = (q_round != '0);
                end
                else if (q_round > {2'b00, etop})
                begin
                    idx_next   = etop;
                    clamp_next = 1'b1;
                end
                else
                begin
                    idx_next   = q_round[IDX_W-1:0];
                    clamp_next = 1'b0;
                end
            end
            S_READ:
            begin
            end
            S_UPDATE:
            begin
                ram_we      = in_range && (act_reg != ACT_READ);
                done_next   = 1'b1;
                oidx_next   = idx_reg;
                ocnt_next   = new_cnt;
                oclamp_next = clamp_reg;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
            step_reg  <= '0;
            act_reg   <= ACT_RANGE;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
            act_reg   <= act_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        smp_reg    <= smp_next;
        idx_reg    <= idx_next;
        clamp_reg  <= clamp_next;
        neg_reg    <= neg_next;
        span_reg   <= span_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        quo_reg    <= quo_next;
        oidx_reg   <= oidx_next;
        ocnt_reg   <= ocnt_next;
        oclamp_reg <= oclamp_next;
    end

    assign done      = done_reg;
    assign bin_index = oidx_reg;
    assign bin_count = ocnt_reg;
    assign clamped   = oclamp_reg;
    assign min_seen  = min_reg;
    assign max_seen  = max_reg;

endmodule

>>> rtl/rnh_checker.sv
// ----------------------------------------------------------------------------
// rnh_checker
// port level checks of the range normalized histogram core
// ----------------------------------------------------------------------------
module rnh_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic signed [SAMPLE_BITS-1:0] min_seen,
    input logic signed [SAMPLE_BITS-1:0] max_seen
);

    // an accepted word keeps the core busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the core busy");

    // a result word follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result word without preceding work");

    // a result word is shown while the core is ready again
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while busy");

    // running range stays ordered
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (min_seen <= max_seen))
        else $error("minimum above maximum");

    // the done strobe lasts a single cycle
    a_no_double_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two result words in a row for one accept");

endmodule

bind range_normalized_histogram_core rnh_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_rnh_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .min_seen (min_seen),
    .max_seen (max_seen)
);
